### sv/ogm_pkg.sv
package ogm_pkg;

  localparam int DEF_GRID_WIDTH  = 256;
  localparam int DEF_GRID_HEIGHT = 256;

  localparam int VAL_W   = 14;
  localparam int COORD_W = 16;
  localparam int PCT_W   = 7;
  localparam int N_EDGES = 50;

  typedef enum logic [1:0] {
    OP_MISS = 2'd0,
    OP_HIT  = 2'd1,
    OP_READ = 2'd2
  } op_t;

  localparam logic [1:0] ST_UNKNOWN  = 2'd0;
  localparam logic [1:0] ST_FREE     = 2'd1;
  localparam logic [1:0] ST_OCCUPIED = 2'd2;

  localparam logic [2:0] REG_HIT_DELTA      = 3'd0;
  localparam logic [2:0] REG_MISS_DELTA     = 3'd1;
  localparam logic [2:0] REG_CLAMP_MIN      = 3'd2;
  localparam logic [2:0] REG_CLAMP_MAX      = 3'd3;
  localparam logic [2:0] REG_OCCUPIED_LEVEL = 3'd4;

  localparam logic signed [VAL_W-1:0] RST_HIT_DELTA      = 14'sd217;
  localparam logic signed [VAL_W-1:0] RST_MISS_DELTA     = -14'sd104;
  localparam logic signed [VAL_W-1:0] RST_CLAMP_MIN      = -14'sd510;
  localparam logic signed [VAL_W-1:0] RST_CLAMP_MAX      = 14'sd890;
  localparam logic signed [VAL_W-1:0] RST_OCCUPIED_LEVEL = 14'sd158;

  // Smallest log-odds value whose rounded percent reaches 51 + i.
  localparam logic signed [VAL_W-1:0] PCT_EDGE [N_EDGES] = '{
    14'sd6,    14'sd16,   14'sd26,   14'sd36,   14'sd47,
    14'sd57,   14'sd67,   14'sd78,   14'sd88,   14'sd99,
    14'sd110,  14'sd120,  14'sd131,  14'sd142,  14'sd153,
    14'sd165,  14'sd176,  14'sd188,  14'sd199,  14'sd211,
    14'sd224,  14'sd236,  14'sd249,  14'sd262,  14'sd275,
    14'sd289,  14'sd303,  14'sd317,  14'sd332,  14'sd347,
    14'sd363,  14'sd380,  14'sd397,  14'sd416,  14'sd435,
    14'sd455,  14'sd476,  14'sd499,  14'sd523,  14'sd549,
    14'sd578,  14'sd609,  14'sd644,  14'sd683,  14'sd729,
    14'sd783,  14'sd850,  14'sd938,  14'sd1072, 14'sd1356
  };

  typedef struct packed {
    logic                    known;
    logic signed [VAL_W-1:0] value;
  } cell_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] hit_delta;
    logic signed [VAL_W-1:0] miss_delta;
    logic signed [VAL_W-1:0] clamp_min;
    logic signed [VAL_W-1:0] clamp_max;
    logic signed [VAL_W-1:0] occupied_level;
  } cfg_t;

  typedef struct packed {
    logic                    valid;
    logic                    in_range;
    logic                    known;
    logic [1:0]              status;
    logic signed [VAL_W-1:0] value;
  } res_t;

endpackage

### sv/ogm_cell_mem.sv
module ogm_cell_mem
  import ogm_pkg::*;
#(
  parameter int DEPTH = DEF_GRID_WIDTH * DEF_GRID_HEIGHT,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  cell_t         wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output cell_t         rd_data
);

  cell_t mem_r [DEPTH];
  cell_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/ogm_clear.sv
module ogm_clear
  import ogm_pkg::*;
#(
  parameter int DEPTH = DEF_GRID_WIDTH * DEF_GRID_HEIGHT,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  output logic          busy,
  output logic [AW-1:0] addr
);

  logic          busy_r, busy_nxt;
  logic [AW-1:0] addr_r, addr_nxt;

  always_comb begin
    busy_nxt = busy_r;
    addr_nxt = addr_r;
    if (busy_r) begin
      if (addr_r == AW'(DEPTH - 1)) begin
        busy_nxt = 1'b0;
      end else begin
        addr_nxt = addr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      addr_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      addr_r <= addr_nxt;
    end
  end

  assign busy = busy_r;
  assign addr = addr_r;

endmodule

### sv/ogm_update.sv
module ogm_update
  import ogm_pkg::*;
#(
  parameter int AW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  logic          load,
  input  logic [1:0]    in_op,
  input  logic          in_range,
  input  logic [AW-1:0] in_addr,
  input  cell_t         rd_data,
  input  cfg_t          cfg,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output cell_t         wr_data,
  output res_t          res
);

  logic          valid_r, valid_nxt;
  logic [1:0]    op_r, op_nxt;
  logic          range_r, range_nxt;
  logic [AW-1:0] addr_r, addr_nxt;

  logic          fwd_valid_r, fwd_valid_nxt;
  logic [AW-1:0] fwd_addr_r, fwd_addr_nxt;
  cell_t         fwd_data_r, fwd_data_nxt;

  cell_t                   cur;
  logic                    is_upd;
  logic signed [VAL_W-1:0] base;
  logic signed [VAL_W-1:0] delta;
  logic signed [VAL_W:0]   sum;
  logic signed [VAL_W:0]   lo_clamped;
  logic signed [VAL_W-1:0] new_value;
  logic                    do_write;

  always_comb begin
    cur = rd_data;
    if (fwd_valid_r && (fwd_addr_r == addr_r)) begin
      cur = fwd_data_r;
    end
    is_upd = (op_r == OP_MISS) || (op_r == OP_HIT);
    base   = cur.known ? cur.value : '0;
    delta  = (op_r == OP_HIT) ? cfg.hit_delta : cfg.miss_delta;
    sum    = $signed({base[VAL_W-1], base}) + $signed({delta[VAL_W-1], delta});
    lo_clamped = sum;
    if (sum < $signed({cfg.clamp_min[VAL_W-1], cfg.clamp_min})) begin
      lo_clamped = $signed({cfg.clamp_min[VAL_W-1], cfg.clamp_min});
    end
    if (lo_clamped > $signed({cfg.clamp_max[VAL_W-1], cfg.clamp_max})) begin
      new_value = cfg.clamp_max;
    end else begin
      new_value = lo_clamped[VAL_W-1:0];
    end
    do_write = valid_r && range_r && is_upd;
  end

  always_comb begin
    res.valid    = valid_r;
    res.in_range = range_r;
    res.known    = range_r && (is_upd || cur.known);
    res.value    = '0;
    res.status   = ST_UNKNOWN;
    if (res.known) begin
      res.value  = is_upd ? new_value : cur.value;
      res.status = (res.value >= cfg.occupied_level) ? ST_OCCUPIED : ST_FREE;
    end
  end

  always_comb begin
    valid_nxt     = valid_r;
    op_nxt        = op_r;
    range_nxt     = range_r;
    addr_nxt      = addr_r;
    fwd_valid_nxt = fwd_valid_r;
    fwd_addr_nxt  = fwd_addr_r;
    fwd_data_nxt  = fwd_data_r;
    if (advance) begin
      valid_nxt     = load;
      op_nxt        = in_op;
      range_nxt     = in_range;
      addr_nxt      = in_addr;
      fwd_valid_nxt = do_write;
      fwd_addr_nxt  = addr_r;
      fwd_data_nxt  = '{known: 1'b1, value: new_value};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      fwd_valid_r <= fwd_valid_nxt;
    end
    op_r       <= op_nxt;
    range_r    <= range_nxt;
    addr_r     <= addr_nxt;
    fwd_addr_r <= fwd_addr_nxt;
    fwd_data_r <= fwd_data_nxt;
  end

  assign wr_en   = do_write && advance;
  assign wr_addr = addr_r;
  assign wr_data = '{known: 1'b1, value: new_value};

endmodule

### sv/ogm_percent.sv
module ogm_percent
  import ogm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  res_t             res_in,
  output res_t             res_out,
  output logic [PCT_W-1:0] percent
);

  res_t                   res_r, res_nxt;
  logic [2*N_EDGES-1:0]   cmp_r, cmp_nxt;

  always_comb begin
    res_nxt = res_r;
    cmp_nxt = cmp_r;
    if (advance) begin
      res_nxt = res_in;
      for (int i = 0; i < N_EDGES; i++) begin
        cmp_nxt[2*i]   = res_in.known && (res_in.value >= PCT_EDGE[i]);
        cmp_nxt[2*i+1] = res_in.known && (res_in.value > -PCT_EDGE[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.valid <= 1'b0;
    end else begin
      res_r.valid <= res_nxt.valid;
    end
    res_r.in_range <= res_nxt.in_range;
    res_r.known    <= res_nxt.known;
    res_r.status   <= res_nxt.status;
    res_r.value    <= res_nxt.value;
    cmp_r          <= cmp_nxt;
  end

  assign res_out = res_r;
  assign percent = PCT_W'($countones(cmp_r));

endmodule

### sv/log_odds_occupancy_grid.sv
// A request passes through the update, percent and output registers in turn.
// Throughput: one request per cycle while in_stall is low; the cell memory is read
// at accept and written back from the update stage, with forwarding between
// neighboring requests. Reset: synchronous; afterwards in_stall stays high
// while every cell is marked unknown. Configuration writes are taken then.
module log_odds_occupancy_grid
  import ogm_pkg::*;
#(
  parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = DEF_GRID_HEIGHT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_op,
  input  logic signed [COORD_W-1:0] in_cell_x,
  input  logic signed [COORD_W-1:0] in_cell_y,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_in_range,
  output logic [1:0]                out_status,
  output logic signed [VAL_W-1:0]   out_cell_value,
  output logic [PCT_W-1:0]          out_percent,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [VAL_W-1:0]          cfg_data
);

  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

  cfg_t cfg_r, cfg_nxt;

  logic          clr_busy;
  logic [AW-1:0] clr_addr;

  logic          advance;
  logic          accept;
  logic          in_range;
  logic [31:0]   idx_full;
  logic [AW-1:0] idx;

  cell_t         rd_data;
  logic          upd_wr_en;
  logic [AW-1:0] upd_wr_addr;
  cell_t         upd_wr_data;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  cell_t         mem_wr_data;

  res_t             s1_res;
  res_t             s2_res;
  logic [PCT_W-1:0] s2_percent;

  logic                    out_valid_r, out_valid_nxt;
  logic                    out_range_r, out_range_nxt;
  logic [1:0]              out_status_r, out_status_nxt;
  logic signed [VAL_W-1:0] out_value_r, out_value_nxt;
  logic [PCT_W-1:0]        out_percent_r, out_percent_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_HIT_DELTA:      cfg_nxt.hit_delta      = cfg_data;
        REG_MISS_DELTA:     cfg_nxt.miss_delta     = cfg_data;
        REG_CLAMP_MIN:      cfg_nxt.clamp_min      = cfg_data;
        REG_CLAMP_MAX:      cfg_nxt.clamp_max      = cfg_data;
        REG_OCCUPIED_LEVEL: cfg_nxt.occupied_level = cfg_data;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hit_delta      <= RST_HIT_DELTA;
      cfg_r.miss_delta     <= RST_MISS_DELTA;
      cfg_r.clamp_min      <= RST_CLAMP_MIN;
      cfg_r.clamp_max      <= RST_CLAMP_MAX;
      cfg_r.occupied_level <= RST_OCCUPIED_LEVEL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign advance  = !(out_valid_r && out_stall);
  assign in_stall = clr_busy || !advance;
  assign accept   = in_valid && !in_stall;

  assign in_range = !in_cell_x[COORD_W-1] && !in_cell_y[COORD_W-1]
                 && (in_cell_x[COORD_W-2:0] < (COORD_W-1)'(GRID_WIDTH))
                 && (in_cell_y[COORD_W-2:0] < (COORD_W-1)'(GRID_HEIGHT));
  assign idx_full = 32'(in_cell_y[COORD_W-2:0]) * 32'(GRID_WIDTH)
                  + 32'(in_cell_x[COORD_W-2:0]);
  assign idx      = idx_full[AW-1:0];

  ogm_clear #(.DEPTH(CELLS), .AW(AW)) u_clear (
    .clk   (clk),
    .rst_n (rst_n),
    .busy  (clr_busy),
    .addr  (clr_addr)
  );

  always_comb begin
    if (clr_busy) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = clr_addr;
      mem_wr_data = '{known: 1'b0, value: '0};
    end else begin
      mem_wr_en   = upd_wr_en;
      mem_wr_addr = upd_wr_addr;
      mem_wr_data = upd_wr_data;
    end
  end

  ogm_cell_mem #(.DEPTH(CELLS), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (accept),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  ogm_update #(.AW(AW)) u_update (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .load     (accept),
    .in_op    (in_op),
    .in_range (in_range),
    .in_addr  (idx),
    .rd_data  (rd_data),
    .cfg      (cfg_r),
    .wr_en    (upd_wr_en),
    .wr_addr  (upd_wr_addr),
    .wr_data  (upd_wr_data),
    .res      (s1_res)
  );

  ogm_percent u_percent (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .res_in  (s1_res),
    .res_out (s2_res),
    .percent (s2_percent)
  );

  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_range_nxt   = out_range_r;
    out_status_nxt  = out_status_r;
    out_value_nxt   = out_value_r;
    out_percent_nxt = out_percent_r;
    if (advance) begin
      out_valid_nxt   = s2_res.valid;
      out_range_nxt   = s2_res.in_range;
      out_status_nxt  = s2_res.status;
      out_value_nxt   = s2_res.value;
      out_percent_nxt = s2_percent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_range_r   <= out_range_nxt;
    out_status_r  <= out_status_nxt;
    out_value_r   <= out_value_nxt;
    out_percent_r <= out_percent_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_in_range   = out_range_r;
  assign out_status     = out_status_r;
  assign out_cell_value = out_value_r;
  assign out_percent    = out_percent_r;

endmodule
